// File: hw/rtl/pwsd_pkg.sv
// shared constants, types and helpers for the page write subpage diff tracker
package pwsd_pkg;

  localparam int PAGE_COUNT    = 64;
  localparam int PAGE_BYTES    = 4096;
  localparam int SUBPAGE_COUNT = 4;

  localparam int SUB_SIZE = (PAGE_BYTES / SUBPAGE_COUNT) > 0 ? (PAGE_BYTES / SUBPAGE_COUNT) : 1;

  localparam int PAGE_IW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int ST_DEPTH = PAGE_COUNT * PAGE_BYTES;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int WIDE_W   = 17;
  localparam int ND_W     = $clog2(SUBPAGE_COUNT + 1);
  localparam int CNT_W    = 32;
  localparam int HIST_BINS = 256;

  // input and output tdata widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 200;

  localparam logic [CNT_W-1:0] SAT32 = '1;

  typedef logic [PAGE_IW-1:0]       page_idx_t;
  typedef logic [OFF_W-1:0]         off_idx_t;
  typedef logic [ST_AW-1:0]         st_addr_t;
  typedef logic [WIDE_W-1:0]        wide_t;
  typedef logic [ND_W-1:0]          nd_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SUBPAGE_COUNT-1:0] sub_t;

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? SAT32 : s[CNT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/page_write_subpage_diff_tracker.sv
// page write tracker: page copy, subpage diff flags, byte histogram and saturating counters
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: page, offset, byte
//  m_axis   out  m_axis_tvalid/m_axis_tready   tuser: is_bin_reply; tdata: report fields
//
//  one item per cycle while no result is stalled; the second stage loads the output register
//  from the registered read of the page, histogram and counter memories for its item
//  reset clears the valid bits of the histogram and per-page counters, so no clearing
//  pass runs; no item is taken while rst is high, and items flow once it is low
//  a stalled output holds back an item that brings a result and those behind it; others keep flowing
module page_write_subpage_diff_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // page_number[15:0], byte_offset[27:16], data_byte[35:28], zero fill
  input  logic [pwsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // page_error[0], was_rewrite[1], subpage_diffs[4:2], page_write_count[36:5],
  // page_diff_sum[68:37], total_writes[100:69], total_rewrites[132:101],
  // total_subpage_diffs[164:133], bin_count[196:165], zero fill
  output logic [pwsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // is_bin_reply
  output logic                                m_axis_tuser
);

  // memories
  logic [7:0]                   store [pwsd_pkg::ST_DEPTH];
  pwsd_pkg::cnt_t               hist  [pwsd_pkg::HIST_BINS];
  logic [2*pwsd_pkg::CNT_W-1:0] cnts  [pwsd_pkg::PAGE_COUNT];

  logic [pwsd_pkg::HIST_BINS-1:0]  hist_valid;
  logic [pwsd_pkg::PAGE_COUNT-1:0] written;

  logic [7:0]                   st_rdata;
  pwsd_pkg::cnt_t               hist_rdata;
  logic [2*pwsd_pkg::CNT_W-1:0] cnt_rdata;

  // input decode
  logic                  accept;
  logic [15:0]           in_page;
  logic [11:0]           in_off;
  logic [7:0]            in_byte;
  pwsd_pkg::wide_t       off_wide;
  pwsd_pkg::page_idx_t   in_page_idx;
  pwsd_pkg::off_idx_t    in_off_idx;
  pwsd_pkg::st_addr_t    in_st_addr;
  pwsd_pkg::sub_t        in_sub;

  // second stage
  logic                  s1_valid;
  logic                  s1_kind;
  logic                  s1_page_ok;
  logic                  s1_off_ok;
  logic                  s1_first;
  logic                  s1_last;
  pwsd_pkg::sub_t        s1_sub;
  pwsd_pkg::page_idx_t   s1_page;
  logic [7:0]            s1_byte;
  pwsd_pkg::st_addr_t    s1_st_addr;
  logic                  s1_st_fwd;
  logic [7:0]            s1_st_fwd_data;
  logic                  s1_hist_fwd;
  pwsd_pkg::cnt_t        s1_hist_fwd_data;
  logic                  s1_cnt_fwd;
  logic [2*pwsd_pkg::CNT_W-1:0] s1_cnt_fwd_data;

  logic                  s1_has_result;
  logic                  s1_fire;
  logic                  wr_byte;
  logic                  wr_close;

  logic [7:0]            st_cur;
  pwsd_pkg::cnt_t        hist_cur;
  pwsd_pkg::cnt_t        hist_new;
  logic [2*pwsd_pkg::CNT_W-1:0] cnt_cur;
  logic [2*pwsd_pkg::CNT_W-1:0] cnt_new;
  logic                  rewrite;
  pwsd_pkg::sub_t        flags_new;
  pwsd_pkg::nd_t         nd;
  logic [2:0]            nd_sat;
  pwsd_pkg::cnt_t        pwc_new;
  pwsd_pkg::cnt_t        pds_new;
  pwsd_pkg::cnt_t        writes_new;
  pwsd_pkg::cnt_t        rewrites_new;
  pwsd_pkg::cnt_t        diffs_new;

  // state registers
  pwsd_pkg::sub_t        flags;
  pwsd_pkg::cnt_t        writes_total;
  pwsd_pkg::cnt_t        rewrites_total;
  pwsd_pkg::cnt_t        diffs_total;

  logic [pwsd_pkg::OUT_DATA_W-1:0] res_data;
  logic                  m_valid;

  assign in_page     = s_axis_tdata[15:0];
  assign in_off      = s_axis_tdata[27:16];
  assign in_byte     = s_axis_tdata[35:28];
  assign off_wide    = pwsd_pkg::wide_t'(in_off);
  assign in_page_idx = in_page[pwsd_pkg::PAGE_IW-1:0];
  assign in_off_idx  = off_wide[pwsd_pkg::OFF_W-1:0];
  assign in_st_addr  = pwsd_pkg::st_addr_t'(in_page_idx) * pwsd_pkg::st_addr_t'(pwsd_pkg::PAGE_BYTES)
                     + pwsd_pkg::st_addr_t'(in_off_idx);

  // subpage of the offset; anything past the last full subpage lands in the last one
  always_comb begin
    for (int k = 0; k < pwsd_pkg::SUBPAGE_COUNT; k++) begin
      in_sub[k] = (off_wide >= pwsd_pkg::wide_t'(k * pwsd_pkg::SUB_SIZE)) &&
                  ((k == pwsd_pkg::SUBPAGE_COUNT - 1) ||
                   (off_wide < pwsd_pkg::wide_t'((k + 1) * pwsd_pkg::SUB_SIZE)));
    end
  end

  assign s1_has_result = s1_kind || (s1_off_ok && s1_last);
  assign s1_fire       = s1_valid && (!s1_has_result || !m_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!s1_valid || s1_fire);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign wr_byte  = s1_fire && !s1_kind && s1_off_ok && s1_page_ok;
  assign wr_close = wr_byte && s1_last;

  // current values with forwarding from the write that went out as this item was read
  assign st_cur   = s1_st_fwd ? s1_st_fwd_data : st_rdata;
  assign hist_cur = s1_hist_fwd ? s1_hist_fwd_data :
                    (hist_valid[s1_byte] ? hist_rdata : '0);
  assign cnt_cur  = s1_cnt_fwd ? s1_cnt_fwd_data :
                    (written[s1_page] ? cnt_rdata : '0);
  assign rewrite  = written[s1_page];

  always_comb begin
    flags_new = s1_first ? '0 : flags;
    if (rewrite && (st_cur != s1_byte)) begin
      flags_new = flags_new | s1_sub;
    end
    nd           = rewrite ? pwsd_pkg::nd_t'($countones(flags_new)) : '0;
    nd_sat       = (nd > pwsd_pkg::nd_t'(7)) ? 3'd7 : nd[2:0];
    hist_new     = pwsd_pkg::sat_add(hist_cur, pwsd_pkg::cnt_t'(1));
    pwc_new      = pwsd_pkg::sat_add(cnt_cur[pwsd_pkg::CNT_W-1:0], pwsd_pkg::cnt_t'(1));
    pds_new      = pwsd_pkg::sat_add(cnt_cur[2*pwsd_pkg::CNT_W-1:pwsd_pkg::CNT_W],
                                     pwsd_pkg::cnt_t'(nd));
    cnt_new      = {pds_new, pwc_new};
    writes_new   = pwsd_pkg::sat_add(writes_total, pwsd_pkg::cnt_t'(1));
    rewrites_new = pwsd_pkg::sat_add(rewrites_total, pwsd_pkg::cnt_t'(rewrite));
    diffs_new    = pwsd_pkg::sat_add(diffs_total, pwsd_pkg::cnt_t'(nd));
  end

  always_comb begin
    res_data = '0;
    if (s1_kind) begin
      res_data[196:165] = hist_cur;
    end else if (!s1_page_ok) begin
      res_data[0]       = 1'b1;
      res_data[100:69]  = writes_total;
      res_data[132:101] = rewrites_total;
      res_data[164:133] = diffs_total;
    end else begin
      res_data[1]       = rewrite;
      res_data[4:2]     = nd_sat;
      res_data[36:5]    = pwc_new;
      res_data[68:37]   = pds_new;
      res_data[100:69]  = writes_new;
      res_data[132:101] = rewrites_new;
      res_data[164:133] = diffs_new;
    end
  end

  // page copy
  always_ff @(posedge clk) begin
    if (accept) begin
      st_rdata <= store[in_st_addr];
    end
    if (wr_byte) begin
      store[s1_st_addr] <= s1_byte;
    end
  end

  // byte histogram
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_rdata <= hist[in_byte];
    end
    if (wr_byte) begin
      hist[s1_byte] <= hist_new;
    end
  end

  // per-page write count and diff sum
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_rdata <= cnts[in_page_idx];
    end
    if (wr_close) begin
      cnts[s1_page] <= cnt_new;
    end
  end

  // second stage payload, forwarding and output data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind          <= s_axis_tuser;
      s1_page_ok       <= {1'b0, in_page} < 17'(pwsd_pkg::PAGE_COUNT);
      s1_off_ok        <= off_wide < pwsd_pkg::wide_t'(pwsd_pkg::PAGE_BYTES);
      s1_first         <= off_wide == '0;
      s1_last          <= off_wide == pwsd_pkg::wide_t'(pwsd_pkg::PAGE_BYTES - 1);
      s1_sub           <= in_sub;
      s1_page          <= in_page_idx;
      s1_byte          <= in_byte;
      s1_st_addr       <= in_st_addr;
      s1_st_fwd        <= wr_byte && (s1_st_addr == in_st_addr);
      s1_st_fwd_data   <= s1_byte;
      s1_hist_fwd      <= wr_byte && (s1_byte == in_byte);
      s1_hist_fwd_data <= hist_new;
      s1_cnt_fwd       <= wr_close && (s1_page == in_page_idx);
      s1_cnt_fwd_data  <= cnt_new;
    end
    if (s1_fire && s1_has_result) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= s1_kind;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      m_valid        <= 1'b0;
      hist_valid     <= '0;
      written        <= '0;
      flags          <= '0;
      writes_total   <= '0;
      rewrites_total <= '0;
      diffs_total    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1_has_result) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      if (wr_byte) begin
        hist_valid[s1_byte] <= 1'b1;
        flags               <= wr_close ? '0 : flags_new;
      end
      if (wr_close) begin
        written[s1_page] <= 1'b1;
        writes_total     <= writes_new;
        rewrites_total   <= rewrites_new;
        diffs_total      <= diffs_new;
      end
    end
  end

  assign m_axis_tvalid = m_valid;

endmodule

// File: dv/page_write_subpage_diff_tracker_tb.sv
// testbench for the page write subpage diff tracker: directed steps, random page traffic, scoreboard
module page_write_subpage_diff_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int LIMIT_CYCLES  = 100_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int OPS_PER_PHASE = 23;

  typedef enum logic { STEP_ONE, STEP_PAGE } step_kind_t;

  typedef struct packed {
    logic            bin_reply;
    logic            page_err;
    logic            rewrite;
    logic [2:0]      diffs;
    pwsd_pkg::cnt_t  page_writes;
    pwsd_pkg::cnt_t  page_diffs;
    pwsd_pkg::cnt_t  all_writes;
    pwsd_pkg::cnt_t  all_rewrites;
    pwsd_pkg::cnt_t  all_diffs;
    pwsd_pkg::cnt_t  bin;
  } report_t;

  // for STEP_PAGE the low bits of data are the mask of subpages to change
  typedef struct {
    step_kind_t  op;
    logic        kind;
    logic [15:0] page;
    logic [11:0] off;
    logic [7:0]  data;
    bit          typed;
    report_t     want;
  } step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [pwsd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [pwsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  // predicted state of the block
  logic [7:0]     page_copy [pwsd_pkg::ST_DEPTH];
  bit             byte_seen [pwsd_pkg::ST_DEPTH];
  pwsd_pkg::cnt_t write_cnt [pwsd_pkg::PAGE_COUNT];
  pwsd_pkg::cnt_t diff_sum [pwsd_pkg::PAGE_COUNT];
  pwsd_pkg::cnt_t hist [pwsd_pkg::HIST_BINS];
  pwsd_pkg::cnt_t writes_all;
  pwsd_pkg::cnt_t rewrites_all;
  pwsd_pkg::cnt_t diffs_all;
  pwsd_pkg::sub_t changed_subs;

  report_t report_q[$];
  step_t   dir_steps[$];
  report_t got_rep;
  report_t want_rep;

  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  page_write_subpage_diff_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic pwsd_pkg::cnt_t bump(input pwsd_pkg::cnt_t a, input int unsigned b);
    logic [pwsd_pkg::CNT_W:0] s;
    s = {1'b0, a} + b;
    return s[pwsd_pkg::CNT_W] ? '1 : s[pwsd_pkg::CNT_W-1:0];
  endfunction

  function automatic int subpage_of(input int o);
    int s;
    s = o / pwsd_pkg::SUB_SIZE;
    if (s >= pwsd_pkg::SUBPAGE_COUNT) s = pwsd_pkg::SUBPAGE_COUNT - 1;
    return s;
  endfunction

  function automatic report_t bin_rep(input pwsd_pkg::cnt_t count);
    report_t r;
    r = '0;
    r.bin_reply = 1'b1;
    r.bin = count;
    return r;
  endfunction

  function automatic report_t err_rep();
    report_t r;
    r = '0;
    r.page_err = 1'b1;
    return r;
  endfunction

  // advances the predicted state by one item; returns 1 when the item yields a result
  function automatic bit predict_report(input logic kind, input logic [15:0] page,
                                        input logic [11:0] off, input logic [7:0] data,
                                        output report_t rep);
    bit  last;
    bit  rw;
    int  p;
    int  addr;
    int  sub;
    int  nd;
    rep = '0;
    if (kind == KIND_READ) begin
      rep.bin_reply = 1'b1;
      rep.bin = hist[data];
      return 1'b1;
    end
    if (int'(off) >= pwsd_pkg::PAGE_BYTES) return 1'b0;
    last = (int'(off) == pwsd_pkg::PAGE_BYTES - 1);
    if (int'(page) >= pwsd_pkg::PAGE_COUNT) begin
      if (!last) return 1'b0;
      rep.page_err     = 1'b1;
      rep.all_writes   = writes_all;
      rep.all_rewrites = rewrites_all;
      rep.all_diffs    = diffs_all;
      return 1'b1;
    end
    p    = int'(page);
    addr = p * pwsd_pkg::PAGE_BYTES + int'(off);
    rw   = (write_cnt[p] != 0);
    sub  = subpage_of(int'(off));
    if (off == 0) changed_subs = '0;
    if (rw && page_copy[addr] != data) changed_subs[sub] = 1'b1;
    page_copy[addr] = data;
    byte_seen[addr] = 1'b1;
    hist[data] = bump(hist[data], 1);
    if (!last) return 1'b0;
    nd = rw ? $countones(changed_subs) : 0;
    if (rw) begin
      diff_sum[p]  = bump(diff_sum[p], nd);
      diffs_all    = bump(diffs_all, nd);
      rewrites_all = bump(rewrites_all, 1);
    end
    write_cnt[p] = bump(write_cnt[p], 1);
    writes_all   = bump(writes_all, 1);
    changed_subs = '0;
    rep.rewrite      = rw;
    rep.diffs        = (nd > 7) ? 3'd7 : 3'(nd);
    rep.page_writes  = write_cnt[p];
    rep.page_diffs   = diff_sum[p];
    rep.all_writes   = writes_all;
    rep.all_rewrites = rewrites_all;
    rep.all_diffs    = diffs_all;
    return 1'b1;
  endfunction

  task automatic offer_item(input logic kind, input logic [15:0] page, input logic [11:0] off,
                            input logic [7:0] data, input bit typed, input report_t typed_rep);
    report_t rep;
    bit      has;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, data, off, page};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    has = predict_report(kind, page, off, data, rep);
    if (typed) report_q.push_back(typed_rep);
    else if (has) report_q.push_back(rep);
  endtask

  task automatic put_byte(input logic [15:0] page, input logic [11:0] off,
                          input logic [7:0] data);
    offer_item(KIND_BYTE, page, off, data, 1'b0, '0);
  endtask

  // page and offset mean nothing to a read, so they carry noise
  task automatic read_bin(input logic [7:0] bin);
    offer_item(KIND_READ, 16'($urandom), 12'($urandom), bin, 1'b0, '0);
  endtask

  // a first write touches a few bytes of each subpage and the last offset;
  // a rewrite revisits exactly the bytes already held, changing at least one in each masked subpage
  task automatic write_page(input int pg, input pwsd_pkg::sub_t mask, input bit mix);
    int         flip [pwsd_pkg::SUBPAGE_COUNT];
    bit         done [pwsd_pkg::SUBPAGE_COUNT];
    int         addr;
    int         sub;
    bit         first;
    bit         send;
    logic [7:0] b;
    first = (write_cnt[pg] == 0);
    for (int s = 0; s < pwsd_pkg::SUBPAGE_COUNT; s++) begin
      flip[s] = s * pwsd_pkg::SUB_SIZE + $urandom_range(0, pwsd_pkg::SUB_SIZE - 1);
      done[s] = 1'b0;
    end
    for (int o = 0; o < pwsd_pkg::PAGE_BYTES; o++) begin
      addr = pg * pwsd_pkg::PAGE_BYTES + o;
      sub  = subpage_of(o);
      if (first)
        send = (o % pwsd_pkg::SUB_SIZE == 0) || (o == flip[sub]) ||
               (o == pwsd_pkg::PAGE_BYTES - 1) || ($urandom_range(0, 1023) == 0);
      else
        send = byte_seen[addr];
      if (send) begin
        if (mix && $urandom_range(0, 19) == 0) read_bin(8'($urandom));
        if (mix && $urandom_range(0, 29) == 0)
          put_byte(16'($urandom_range(pwsd_pkg::PAGE_COUNT, 65535)), 12'($urandom),
                   8'($urandom));
        if (first) b = 8'($urandom);
        else if (!mask[sub]) b = page_copy[addr];
        else if (!done[sub]) begin
          b = page_copy[addr] ^ 8'($urandom_range(1, 255));
          done[sub] = 1'b1;
        end else if ($urandom_range(0, 3) == 0) b = 8'($urandom);
        else b = page_copy[addr];
        put_byte(16'(pg), 12'(o), b);
      end
    end
  endtask

  function automatic int pick_page();
    return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 5) :
                                          $urandom_range(0, pwsd_pkg::PAGE_COUNT - 1);
  endfunction

  task automatic add_step(input step_kind_t op, input logic kind, input logic [15:0] page,
                          input logic [11:0] off, input logic [7:0] data,
                          input bit typed, input report_t want);
    step_t st;
    st.op = op; st.kind = kind; st.page = page; st.off = off; st.data = data;
    st.typed = typed; st.want = want;
    dir_steps.push_back(st);
  endtask

  task automatic check_field(input string name, input pwsd_pkg::cnt_t want,
                             input pwsd_pkg::cnt_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_rep.bin_reply    = m_axis_tuser;
      got_rep.page_err     = m_axis_tdata[0];
      got_rep.rewrite      = m_axis_tdata[1];
      got_rep.diffs        = m_axis_tdata[4:2];
      got_rep.page_writes  = m_axis_tdata[36:5];
      got_rep.page_diffs   = m_axis_tdata[68:37];
      got_rep.all_writes   = m_axis_tdata[100:69];
      got_rep.all_rewrites = m_axis_tdata[132:101];
      got_rep.all_diffs    = m_axis_tdata[164:133];
      got_rep.bin          = m_axis_tdata[196:165];
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: result mismatch, expected none, got tuser %0b tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want_rep = report_q.pop_front();
        check_field("is_bin_reply", want_rep.bin_reply, got_rep.bin_reply);
        check_field("page_error", want_rep.page_err, got_rep.page_err);
        check_field("was_rewrite", want_rep.rewrite, got_rep.rewrite);
        check_field("subpage_diffs", want_rep.diffs, got_rep.diffs);
        check_field("page_write_count", want_rep.page_writes, got_rep.page_writes);
        check_field("page_diff_sum", want_rep.page_diffs, got_rep.page_diffs);
        check_field("total_writes", want_rep.all_writes, got_rep.all_writes);
        check_field("total_rewrites", want_rep.all_rewrites, got_rep.all_rewrites);
        check_field("total_subpage_diffs", want_rep.all_diffs, got_rep.all_diffs);
        check_field("bin_count", want_rep.bin, got_rep.bin);
      end
    end
  end

  initial begin
    int r;
    int pg;
    int o;
    int cnt;
    for (int i = 0; i < pwsd_pkg::PAGE_COUNT; i++) begin
      write_cnt[i] = '0;
      diff_sum[i]  = '0;
    end
    for (int i = 0; i < pwsd_pkg::HIST_BINS; i++) hist[i] = '0;
    writes_all   = '0;
    rewrites_all = '0;
    diffs_all    = '0;
    changed_subs = '0;
    tx_idle_pct  = 24;
    rx_idle_pct  = 81;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // fresh counters, page number extremes, then writes and rewrites of the edge pages
    add_step(STEP_ONE, KIND_READ, 16'd0, 12'd0, 8'h00, 1'b1, bin_rep(0));
    add_step(STEP_ONE, KIND_READ, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1, bin_rep(0));
    add_step(STEP_ONE, KIND_BYTE, 16'hFFFF, 12'hFFF, 8'hFF, 1'b1, err_rep());
    add_step(STEP_ONE, KIND_BYTE, 16'd64, 12'hFFF, 8'h00, 1'b1, err_rep());
    add_step(STEP_ONE, KIND_BYTE, 16'h8000, 12'd0, 8'h5A, 1'b0, '0);
    // bytes of a bad page are not counted
    add_step(STEP_ONE, KIND_READ, 16'd0, 12'd0, 8'h5A, 1'b1, bin_rep(0));
    add_step(STEP_PAGE, KIND_BYTE, 16'd0, 12'd0, 8'h0, 1'b0, '0);
    add_step(STEP_PAGE, KIND_BYTE, 16'd0, 12'd0, 8'h0, 1'b0, '0);
    add_step(STEP_PAGE, KIND_BYTE, 16'd0, 12'd0, 8'hF, 1'b0, '0);
    add_step(STEP_PAGE, KIND_BYTE, 16'd0, 12'd0, 8'h5, 1'b0, '0);
    add_step(STEP_PAGE, KIND_BYTE, 16'd63, 12'd0, 8'h0, 1'b0, '0);
    // broken-off write, then a full one must not see its flags
    add_step(STEP_ONE, KIND_BYTE, 16'd63, 12'd0, 8'h3C, 1'b0, '0);
    add_step(STEP_ONE, KIND_BYTE, 16'd63, 12'd1024, 8'hC3, 1'b0, '0);
    add_step(STEP_PAGE, KIND_BYTE, 16'd63, 12'd0, 8'h8, 1'b0, '0);
    // write with missing bytes closed by the last offset
    add_step(STEP_ONE, KIND_BYTE, 16'd63, 12'd2048, 8'hC3, 1'b0, '0);
    add_step(STEP_ONE, KIND_BYTE, 16'd63, 12'hFFF, 8'h00, 1'b0, '0);
    add_step(STEP_ONE, KIND_BYTE, 16'd64, 12'hFFF, 8'h11, 1'b0, '0);
    add_step(STEP_ONE, KIND_READ, 16'd7, 12'd9, 8'h00, 1'b0, '0);
    add_step(STEP_ONE, KIND_READ, 16'd0, 12'd0, 8'hFF, 1'b0, '0);
    add_step(STEP_ONE, KIND_BYTE, 16'd0, 12'hFFF, 8'hFF, 1'b0, '0);
    add_step(STEP_ONE, KIND_BYTE, 16'hFFFF, 12'd0, 8'h00, 1'b0, '0);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].op == STEP_PAGE)
        write_page(int'(dir_steps[i].page), pwsd_pkg::sub_t'(dir_steps[i].data), 1'b0);
      else
        offer_item(dir_steps[i].kind, dir_steps[i].page, dir_steps[i].off,
                   dir_steps[i].data, dir_steps[i].typed, dir_steps[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 24 : 0;
      if (ph == 2) begin
        // long output stall while reads keep coming, so the input backs up
        hold_req++;
        repeat (40) read_bin(8'($urandom));
      end
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        r  = $urandom_range(0, 99);
        pg = pick_page();
        if (r < 25) begin
          write_page(pg, pwsd_pkg::sub_t'($urandom), 1'b1);
        end else if (r < 45) begin
          read_bin(8'($urandom));
        end else if (r < 55) begin
          // write broken off early; a written page is revisited only where its copy is held
          cnt = $urandom_range(1, 8);
          o   = 0;
          while (cnt != 0 && o < pwsd_pkg::PAGE_BYTES - 1) begin
            if (write_cnt[pg] == 0 || byte_seen[pg * pwsd_pkg::PAGE_BYTES + o]) begin
              put_byte(16'(pg), 12'(o), 8'($urandom));
              cnt--;
            end
            o++;
          end
        end else if (r < 68) begin
          // rewrite that skips some held bytes, closed by the last offset; a fresh page gets a first write
          if (write_cnt[pg] == 0) begin
            write_page(pg, '0, 1'b1);
          end else begin
            for (o = 0; o < pwsd_pkg::PAGE_BYTES - 1; o++) begin
              if (byte_seen[pg * pwsd_pkg::PAGE_BYTES + o] && $urandom_range(0, 1))
                put_byte(16'(pg), 12'(o), $urandom_range(0, 1) ?
                         page_copy[pg * pwsd_pkg::PAGE_BYTES + o] : 8'($urandom));
            end
            put_byte(16'(pg), 12'(pwsd_pkg::PAGE_BYTES - 1), 8'($urandom));
          end
        end else if (r < 80) begin
          pg  = $urandom_range(pwsd_pkg::PAGE_COUNT, 65535);
          cnt = $urandom_range(1, 4);
          repeat (cnt)
            put_byte(16'(pg), 12'($urandom_range(0, pwsd_pkg::PAGE_BYTES - 2)), 8'($urandom));
          if ($urandom_range(0, 1))
            put_byte(16'(pg), 12'(pwsd_pkg::PAGE_BYTES - 1), 8'($urandom));
        end else if (r < 92) begin
          // stray byte; on a written page it lands only where the copy is held
          o = $urandom_range(0, pwsd_pkg::PAGE_BYTES - 1);
          if (write_cnt[pg] != 0 && !byte_seen[pg * pwsd_pkg::PAGE_BYTES + o])
            o = pwsd_pkg::PAGE_BYTES - 1;
          put_byte(16'(pg), 12'(o), 8'($urandom));
        end else begin
          repeat ($urandom_range(5, 15)) read_bin(8'($urandom));
        end
      end
    end

    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && report_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pwsd_pkg.sv
hw/rtl/page_write_subpage_diff_tracker.sv
dv/page_write_subpage_diff_tracker_tb.sv
